/* hw/rtl/modbus_rtu_master_engine_macros.svh */
// Assertion helpers for the Modbus RTU master engine
`ifndef MODBUS_RTU_MASTER_ENGINE_MACROS_SVH
`define MODBUS_RTU_MASTER_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MRM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define MRM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mrm_pkg.sv */
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, codes and helper functions of the Modbus RTU master engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mrm_pkg;

    // Store sizes
    localparam int TX_WORDS   = 64;
    localparam int RESP_WORDS = 64;
    localparam int TX_AW      = $clog2(TX_WORDS);
    localparam int RS_AW      = $clog2(RESP_WORDS);

    // Write quantity and response length limits
    localparam int COIL_BYTES = (2 * TX_WORDS < 246) ? 2 * TX_WORDS : 246;
    localparam int COIL_LIM   = 8 * COIL_BYTES;
    localparam int REG10_LIM  = (TX_WORDS < 123) ? TX_WORDS : 123;
    localparam int REG17_LIM  = (TX_WORDS < 121) ? TX_WORDS : 121;
    localparam int RLEN_MAX   = (RESP_WORDS < 127) ? RESP_WORDS : 127;

    // Request types
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_PULL  = 3'd2;
    localparam logic [2:0] REQ_RX    = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;
    localparam logic [2:0] REQ_READ  = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXC     = 3'd1;
    localparam logic [2:0] ST_SLAVE   = 3'd2;
    localparam logic [2:0] ST_FUNC    = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_CRC     = 3'd5;
    localparam logic [2:0] ST_INDEX   = 3'd6;

    // Transaction phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_TX   = 3'd1;
    localparam logic [2:0] PH_HEAD = 3'd2;
    localparam logic [2:0] PH_EXC  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CRC  = 3'd5;

    // Function codes
    localparam logic [7:0] FC_RD_COILS = 8'h01;
    localparam logic [7:0] FC_RD_DISC  = 8'h02;
    localparam logic [7:0] FC_RD_HOLD  = 8'h03;
    localparam logic [7:0] FC_RD_INPUT = 8'h04;
    localparam logic [7:0] FC_WR_COIL  = 8'h05;
    localparam logic [7:0] FC_WR_REG   = 8'h06;
    localparam logic [7:0] FC_WR_COILS = 8'h0F;
    localparam logic [7:0] FC_WR_REGS  = 8'h10;
    localparam logic [7:0] FC_MASK_WR  = 8'h16;
    localparam logic [7:0] FC_RW_REGS  = 8'h17;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  slave_id;
        logic [7:0]  function_code;
        logic [15:0] read_address;
        logic [15:0] read_quantity;
        logic [15:0] write_address;
        logic [15:0] write_quantity;
        logic [5:0]  word_index;
        logic [15:0] word_value;
        logic [7:0]  rx_byte;
    } t_mrm_req;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        done_res;
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic [15:0] resp_word;
        logic [6:0]  resp_count;
    } t_mrm_res;

    // One byte of CRC-16, reflected polynomial 0xA001
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic is_read(input logic [7:0] fc);
        return (fc == FC_RD_COILS) || (fc == FC_RD_DISC) || (fc == FC_RD_HOLD) ||
               (fc == FC_RD_INPUT) || (fc == FC_RW_REGS);
    endfunction

    function automatic logic is_supported(input logic [7:0] fc);
        return (fc >= FC_RD_COILS && fc <= FC_WR_REG) || (fc == FC_WR_COILS) ||
               (fc == FC_WR_REGS) || (fc == FC_MASK_WR) || (fc == FC_RW_REGS);
    endfunction

    // Bytes before the data field of a request frame
    function automatic logic [7:0] head_len(input logic [7:0] fc);
        logic [7:0] n;
        case (fc)
            FC_WR_COILS, FC_WR_REGS: n = 8'd7;
            FC_MASK_WR:              n = 8'd8;
            FC_RW_REGS:              n = 8'd11;
            default:                 n = 8'd6;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mrm_ram.sv */
// ----------------------------------------------------------------------------
// mrm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mrm_engine.sv */
// ----------------------------------------------------------------------------
// mrm_engine
// Request pipeline and transaction sequencer: issues store reads on accept,
// executes one request per cycle unless stalled and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_master_engine_macros.svh"

module mrm_engine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire mrm_pkg::t_mrm_req          i_req,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output mrm_pkg::t_mrm_res               o_res,
    input  wire logic                       i_cfg_we,
    input  wire logic [15:0]                i_cfg_data,
    output logic                            o_tx_we,
    output logic [mrm_pkg::TX_AW-1:0]       o_tx_waddr,
    output logic [15:0]                     o_tx_wdata,
    output logic                            o_tx_re,
    output logic [mrm_pkg::TX_AW-1:0]       o_tx_raddr,
    input  wire logic [15:0]                i_tx_rdata,
    output logic                            o_rs_we,
    output logic [mrm_pkg::RS_AW:0]         o_rs_waddr,
    output logic [15:0]                     o_rs_wdata,
    output logic                            o_rs_re,
    output logic [mrm_pkg::RS_AW:0]         o_rs_raddr,
    input  wire logic [15:0]                i_rs_rdata
);

    // Pipeline registers
    logic                       r_s1_vld;
    mrm_pkg::t_mrm_req          r_s1;
    logic                       r_out_vld;
    mrm_pkg::t_mrm_res          r_out;

    // Transaction state
    logic [2:0]                 r_phase, n_phase;
    logic [7:0]                 r_pos, n_pos;
    logic [15:0]                r_crc, n_crc;
    logic [7:0]                 r_left, n_left;
    logic [15:0]                r_elapsed, n_elapsed;
    logic [15:0]                r_raddr, n_raddr;
    logic [15:0]                r_rqty, n_rqty;
    logic [15:0]                r_waddr, n_waddr;
    logic [15:0]                r_wqty, n_wqty;
    logic [7:0]                 r_slave, n_slave;
    logic [7:0]                 r_fc, n_fc;
    logic [7:0]                 r_pend, n_pend;
    logic [6:0]                 r_rlen, n_rlen;
    logic [15:0]                r_tmo;
    logic [mrm_pkg::RESP_WORDS-1:0] r_sel, n_sel;
    logic [mrm_pkg::RESP_WORDS-1:0] r_rvld, n_rvld;

    logic                       w_adv;
    logic                       w_acc;
    logic                       w_exec;
    mrm_pkg::t_mrm_res          w_res;

    // Frame assembly
    logic [7:0]                 w_hdr [16];
    logic [7:0]                 w_hl;
    logic [7:0]                 w_dl;
    logic [8:0]                 w_body;
    logic [7:0]                 w_doff;
    logic                       w_dhi;
    logic [7:0]                 w_txb;
    logic [7:0]                 w_rxb;
    logic [15:0]                w_crc_rx;

    // Start and commit helpers
    logic [15:0]                w_wq_sat;
    logic                       w_commit;
    logic [8:0]                 w_cnt;
    logic [8:0]                 w_cnt_sat;
    logic [7:0]                 w_wi;
    logic [15:0]                w_elap_inc;

    // Read address helpers
    logic [7:0]                 w_idx;
    logic [7:0]                 w_nhl;
    logic [7:0]                 w_ndoff;

    // Handshake: the pipeline moves whenever the output register is free
    assign w_adv   = !(r_out_vld && i_stall);
    assign o_stall = r_s1_vld && !w_adv;
    assign w_acc   = i_valid && !o_stall;
    assign w_exec  = w_adv && r_s1_vld;
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    // Build the header bytes of the current request
    always_comb begin
        w_hl = mrm_pkg::head_len(r_fc);
        case (r_fc)
            mrm_pkg::FC_WR_COILS: w_dl = 8'((17'(r_wqty) + 17'd7) >> 3);
            mrm_pkg::FC_WR_REGS,
            mrm_pkg::FC_RW_REGS:  w_dl = {r_wqty[6:0], 1'b0};
            default:              w_dl = 8'd0;
        endcase
        w_body = 9'(w_hl) + 9'(w_dl);
        for (int k = 0; k < 16; k++) begin
            w_hdr[k] = 8'h00;
        end
        w_hdr[0] = r_slave;
        w_hdr[1] = r_fc;
        case (r_fc)
            mrm_pkg::FC_RD_COILS, mrm_pkg::FC_RD_DISC,
            mrm_pkg::FC_RD_HOLD, mrm_pkg::FC_RD_INPUT: begin
                w_hdr[2] = r_raddr[15:8];
                w_hdr[3] = r_raddr[7:0];
                w_hdr[4] = r_rqty[15:8];
                w_hdr[5] = r_rqty[7:0];
            end
            mrm_pkg::FC_WR_COIL: begin
                w_hdr[2] = r_waddr[15:8];
                w_hdr[3] = r_waddr[7:0];
                w_hdr[4] = r_wqty[15:8];
                w_hdr[5] = r_wqty[7:0];
            end
            mrm_pkg::FC_WR_REG: begin
                w_hdr[2] = r_waddr[15:8];
                w_hdr[3] = r_waddr[7:0];
                w_hdr[4] = i_tx_rdata[15:8];
                w_hdr[5] = i_tx_rdata[7:0];
            end
            mrm_pkg::FC_WR_COILS, mrm_pkg::FC_WR_REGS: begin
                w_hdr[2] = r_waddr[15:8];
                w_hdr[3] = r_waddr[7:0];
                w_hdr[4] = r_wqty[15:8];
                w_hdr[5] = r_wqty[7:0];
                w_hdr[6] = w_dl;
            end
            mrm_pkg::FC_MASK_WR: begin
                w_hdr[2] = r_waddr[15:8];
                w_hdr[3] = r_waddr[7:0];
                w_hdr[4] = i_tx_rdata[15:8];
                w_hdr[5] = i_tx_rdata[7:0];
                w_hdr[6] = i_tx_rdata[15:8];
                w_hdr[7] = i_tx_rdata[7:0];
            end
            mrm_pkg::FC_RW_REGS: begin
                w_hdr[2]  = r_raddr[15:8];
                w_hdr[3]  = r_raddr[7:0];
                w_hdr[4]  = r_rqty[15:8];
                w_hdr[5]  = r_rqty[7:0];
                w_hdr[6]  = r_waddr[15:8];
                w_hdr[7]  = r_waddr[7:0];
                w_hdr[8]  = r_wqty[15:8];
                w_hdr[9]  = r_wqty[7:0];
                w_hdr[10] = w_dl;
            end
            default: begin
                w_hdr[2] = 8'h00;
            end
        endcase
        // Pick the byte at the current frame position
        w_doff = r_pos - w_hl;
        w_dhi  = (r_fc == mrm_pkg::FC_WR_COILS) ? w_doff[0] : !w_doff[0];
        if (r_pos < w_hl) begin
            w_txb = w_hdr[r_pos[3:0]];
        end else if (9'(r_pos) < w_body) begin
            w_txb = w_dhi ? i_tx_rdata[15:8] : i_tx_rdata[7:0];
        end else if (9'(r_pos) == w_body) begin
            w_txb = r_crc[7:0];
        end else begin
            w_txb = r_crc[15:8];
        end
    end

    // Saturate the write quantity of a start
    always_comb begin
        w_wq_sat = r_s1.write_quantity;
        case (r_s1.function_code)
            mrm_pkg::FC_WR_COILS: begin
                if (w_wq_sat > 16'(mrm_pkg::COIL_LIM)) w_wq_sat = 16'(mrm_pkg::COIL_LIM);
            end
            mrm_pkg::FC_WR_REGS: begin
                if (w_wq_sat > 16'(mrm_pkg::REG10_LIM)) w_wq_sat = 16'(mrm_pkg::REG10_LIM);
            end
            mrm_pkg::FC_RW_REGS: begin
                if (w_wq_sat > 16'(mrm_pkg::REG17_LIM)) w_wq_sat = 16'(mrm_pkg::REG17_LIM);
            end
            default: begin
                w_wq_sat = r_s1.write_quantity;
            end
        endcase
    end

    // Execute the request held in the first stage
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_left    = r_left;
        n_elapsed = r_elapsed;
        n_raddr   = r_raddr;
        n_rqty    = r_rqty;
        n_waddr   = r_waddr;
        n_wqty    = r_wqty;
        n_slave   = r_slave;
        n_fc      = r_fc;
        n_pend    = r_pend;
        n_rlen    = r_rlen;
        w_res     = '0;
        w_commit  = 1'b0;
        o_rs_we   = 1'b0;
        o_rs_wdata = 16'h0000;
        w_rxb     = r_s1.rx_byte;
        w_crc_rx  = mrm_pkg::crc_step(r_crc, w_rxb);
        w_wi      = r_pos >> 1;
        o_rs_waddr = {!r_sel[w_wi[mrm_pkg::RS_AW-1:0]], w_wi[mrm_pkg::RS_AW-1:0]};
        w_idx     = 8'(r_s1.word_index);
        w_elap_inc = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
        if (w_exec) begin
            case (r_s1.req_type)
                mrm_pkg::REQ_LOAD: begin
                    if (w_idx >= 8'(mrm_pkg::TX_WORDS)) w_res.status = mrm_pkg::ST_INDEX;
                end
                mrm_pkg::REQ_START: begin
                    if (r_phase == mrm_pkg::PH_IDLE) begin
                        if (!mrm_pkg::is_supported(r_s1.function_code)) begin
                            w_res.done_res = 1'b1;
                            w_res.status   = mrm_pkg::ST_FUNC;
                            n_pos  = 8'd0;
                            n_left = 8'd0;
                        end else begin
                            n_slave   = r_s1.slave_id;
                            n_fc      = r_s1.function_code;
                            n_raddr   = r_s1.read_address;
                            n_rqty    = r_s1.read_quantity;
                            n_waddr   = r_s1.write_address;
                            n_wqty    = w_wq_sat;
                            n_phase   = mrm_pkg::PH_TX;
                            n_pos     = 8'd0;
                            n_crc     = 16'hFFFF;
                            n_elapsed = 16'd0;
                        end
                    end
                end
                mrm_pkg::REQ_PULL: begin
                    if (r_phase == mrm_pkg::PH_TX) begin
                        w_res.tx_valid = 1'b1;
                        w_res.tx_byte  = w_txb;
                        if (9'(r_pos) < w_body) n_crc = mrm_pkg::crc_step(r_crc, w_txb);
                        if (9'(r_pos) > w_body) begin
                            w_res.tx_last = 1'b1;
                            n_phase   = mrm_pkg::PH_HEAD;
                            n_pos     = 8'd0;
                            n_crc     = 16'hFFFF;
                            n_elapsed = 16'd0;
                        end else begin
                            n_pos = r_pos + 8'd1;
                        end
                    end
                end
                mrm_pkg::REQ_RX: begin
                    if (r_phase >= mrm_pkg::PH_HEAD) begin
                        n_crc = w_crc_rx;
                        case (r_phase)
                            mrm_pkg::PH_HEAD: begin
                                if (r_pos == 8'd0) begin
                                    if (w_rxb != r_slave) begin
                                        w_res.done_res = 1'b1;
                                        w_res.status   = mrm_pkg::ST_SLAVE;
                                        n_phase = mrm_pkg::PH_IDLE;
                                        n_pos   = 8'd0;
                                        n_left  = 8'd0;
                                    end else begin
                                        n_pos = 8'd1;
                                    end
                                end else if (r_pos == 8'd1) begin
                                    if ({1'b0, w_rxb[6:0]} != r_fc) begin
                                        w_res.done_res = 1'b1;
                                        w_res.status   = mrm_pkg::ST_FUNC;
                                        n_phase = mrm_pkg::PH_IDLE;
                                        n_pos   = 8'd0;
                                        n_left  = 8'd0;
                                    end else if (w_rxb[7]) begin
                                        n_phase = mrm_pkg::PH_EXC;
                                    end else begin
                                        n_pos = 8'd2;
                                    end
                                end else begin
                                    n_pos = 8'd0;
                                    if (mrm_pkg::is_read(r_fc)) begin
                                        if (w_rxb == 8'd0) begin
                                            n_phase = mrm_pkg::PH_CRC;
                                            n_left  = 8'd2;
                                        end else begin
                                            n_phase = mrm_pkg::PH_DATA;
                                            n_left  = w_rxb;
                                        end
                                    end else begin
                                        // first echo byte is already in
                                        n_phase = mrm_pkg::PH_DATA;
                                        n_left  = (r_fc == mrm_pkg::FC_MASK_WR) ? 8'd5 : 8'd3;
                                    end
                                end
                            end
                            mrm_pkg::PH_EXC: begin
                                w_res.done_res       = 1'b1;
                                w_res.status         = mrm_pkg::ST_EXC;
                                w_res.exception_code = w_rxb;
                                n_phase = mrm_pkg::PH_IDLE;
                                n_pos   = 8'd0;
                                n_left  = 8'd0;
                            end
                            mrm_pkg::PH_DATA: begin
                                // unpack read data into the staging bank
                                if (mrm_pkg::is_read(r_fc) &&
                                    w_wi < 8'(mrm_pkg::RESP_WORDS)) begin
                                    if (r_fc == mrm_pkg::FC_RD_COILS ||
                                        r_fc == mrm_pkg::FC_RD_DISC) begin
                                        o_rs_we = 1'b1;
                                        if (r_pos[0]) begin
                                            o_rs_wdata = {w_rxb, r_pend};
                                        end else begin
                                            o_rs_wdata = {8'h00, w_rxb};
                                            n_pend     = w_rxb;
                                        end
                                    end else begin
                                        if (r_pos[0]) begin
                                            o_rs_we    = 1'b1;
                                            o_rs_wdata = {r_pend, w_rxb};
                                        end else begin
                                            n_pend = w_rxb;
                                        end
                                    end
                                end
                                n_pos  = r_pos + 8'd1;
                                n_left = r_left - 8'd1;
                                if (r_left == 8'd1) begin
                                    n_phase = mrm_pkg::PH_CRC;
                                    n_left  = 8'd2;
                                end
                            end
                            default: begin
                                n_left = r_left - 8'd1;
                                if (r_left == 8'd1) begin
                                    w_res.done_res = 1'b1;
                                    n_phase = mrm_pkg::PH_IDLE;
                                    n_pos   = 8'd0;
                                    n_left  = 8'd0;
                                    if (w_crc_rx == 16'h0000) begin
                                        w_res.status = mrm_pkg::ST_OK;
                                        w_commit     = mrm_pkg::is_read(r_fc);
                                    end else begin
                                        w_res.status = mrm_pkg::ST_CRC;
                                    end
                                end
                            end
                        endcase
                    end
                end
                mrm_pkg::REQ_TICK: begin
                    if (r_phase >= mrm_pkg::PH_HEAD) begin
                        n_elapsed = w_elap_inc;
                        if (w_elap_inc > r_tmo) begin
                            w_res.done_res = 1'b1;
                            w_res.status   = mrm_pkg::ST_TIMEOUT;
                            n_phase = mrm_pkg::PH_IDLE;
                            n_pos   = 8'd0;
                            n_left  = 8'd0;
                        end
                    end
                end
                mrm_pkg::REQ_READ: begin
                    if (w_idx < 8'(mrm_pkg::RESP_WORDS)) begin
                        w_res.resp_word = r_rvld[w_idx[mrm_pkg::RS_AW-1:0]] ?
                                          i_rs_rdata : 16'h0000;
                    end else begin
                        w_res.status = mrm_pkg::ST_INDEX;
                    end
                end
                default: begin
                    w_res = '0;
                end
            endcase
        end
        // Commit count of a good read reply
        if (r_fc == mrm_pkg::FC_RD_COILS || r_fc == mrm_pkg::FC_RD_DISC) begin
            w_cnt = (9'(r_pos) + 9'd1) >> 1;
        end else begin
            w_cnt = 9'(r_pos) >> 1;
        end
        w_cnt_sat = (w_cnt > 9'(mrm_pkg::RLEN_MAX)) ? 9'(mrm_pkg::RLEN_MAX) : w_cnt;
        if (w_commit) n_rlen = w_cnt_sat[6:0];
        w_res.resp_count = n_rlen;
    end

    // Flip committed words over to the freshly staged bank
    always_comb begin
        for (int i = 0; i < mrm_pkg::RESP_WORDS; i++) begin
            n_sel[i]  = r_sel[i] ^ (w_commit && (9'(i) < w_cnt));
            n_rvld[i] = r_rvld[i] | (w_commit && (9'(i) < w_cnt));
        end
    end

    // Issue store accesses for the request being accepted
    always_comb begin
        o_tx_we    = w_acc && (i_req.req_type == mrm_pkg::REQ_LOAD) &&
                     (8'(i_req.word_index) < 8'(mrm_pkg::TX_WORDS));
        o_tx_waddr = mrm_pkg::TX_AW'(i_req.word_index);
        o_tx_wdata = i_req.word_value;
        o_tx_re    = w_acc;
        w_nhl      = mrm_pkg::head_len(n_fc);
        w_ndoff    = n_pos - w_nhl;
        case (n_fc)
            mrm_pkg::FC_WR_REG:  o_tx_raddr = '0;
            mrm_pkg::FC_MASK_WR: o_tx_raddr = mrm_pkg::TX_AW'(n_pos >= 8'd6);
            default:             o_tx_raddr = w_ndoff[mrm_pkg::TX_AW:1];
        endcase
        o_rs_re    = w_acc;
        o_rs_raddr = {n_sel[mrm_pkg::RS_AW'(i_req.word_index)],
                      mrm_pkg::RS_AW'(i_req.word_index)};
    end

    // Advance the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_vld  <= w_acc;
                r_out_vld <= r_s1_vld;
            end else if (w_acc) begin
                r_s1_vld <= 1'b1;
            end
        end
    end

    // Hold payload of both stages
    always_ff @(posedge i_clk) begin
        if (w_acc) r_s1 <= i_req;
        if (w_adv) r_out <= w_res;
    end

    // Update transaction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mrm_pkg::PH_IDLE;
            r_pos     <= 8'd0;
            r_crc     <= 16'hFFFF;
            r_left    <= 8'd0;
            r_elapsed <= 16'd0;
            r_raddr   <= 16'd0;
            r_rqty    <= 16'd0;
            r_waddr   <= 16'd0;
            r_wqty    <= 16'd0;
            r_slave   <= 8'd0;
            r_fc      <= 8'd0;
            r_pend    <= 8'd0;
            r_rlen    <= 7'd0;
            r_tmo     <= 16'd2000;
            r_sel     <= '0;
            r_rvld    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_left    <= n_left;
            r_elapsed <= n_elapsed;
            r_raddr   <= n_raddr;
            r_rqty    <= n_rqty;
            r_waddr   <= n_waddr;
            r_wqty    <= n_wqty;
            r_slave   <= n_slave;
            r_fc      <= n_fc;
            r_pend    <= n_pend;
            r_rlen    <= n_rlen;
            r_sel     <= n_sel;
            r_rvld    <= n_rvld;
            if (i_cfg_we) r_tmo <= i_cfg_data;
        end
    end

    // Checks
    `MRM_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n, o_stall, r_s1_vld, "stall with empty stage")
    `MRM_ASSERT_NXT(a_done_goes_idle, i_clk, i_rst_n, w_exec && w_res.done_res, r_phase == mrm_pkg::PH_IDLE, "done without idle")
    `MRM_ASSERT_NOW(a_idle_clean, i_clk, i_rst_n, r_phase == mrm_pkg::PH_IDLE, r_pos == 8'd0 && r_left == 8'd0, "idle with stale counters")
    `MRM_ASSERT_NOW(a_last_is_tx, i_clk, i_rst_n, o_valid && o_res.tx_last, o_res.tx_valid && !o_res.done_res, "last byte flag on a non-byte result")

endmodule

`default_nettype wire

/* hw/rtl/modbus_rtu_master_engine.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_master_engine
// Modbus RTU master: frame builder, reply checker and response store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid / o_stall with payload i_req; each gives exactly
//   one result on o_valid / i_stall with payload o_res. Software loads write
//   words, starts a transaction, pulls request frame bytes for the UART, feeds
//   reply bytes and millisecond ticks, then reads response words.
//   A request passes the first stage, then the output register; one request
//   is accepted every cycle while o_stall is low. Both stores are read once
//   on accept, before the state update. The user must write the timeout
//   register via i_cfg_we / i_cfg_data only while idle; the block does not enforce this.
//   Reset (i_rst_n low, synchronous) clears the pipeline, returns to idle,
//   restores a 2000 ms timeout and clears the response store through its
//   per-word valid bits, so no clearing pass is needed.
//   When the receiver stalls, the result is held in the output register, one
//   more request may be taken into the first stage, then o_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_master_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire mrm_pkg::t_mrm_req i_req,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output mrm_pkg::t_mrm_res      o_res,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_data
);

    logic                        w_tx_we;
    logic [mrm_pkg::TX_AW-1:0]   w_tx_waddr;
    logic [15:0]                 w_tx_wdata;
    logic                        w_tx_re;
    logic [mrm_pkg::TX_AW-1:0]   w_tx_raddr;
    logic [15:0]                 w_tx_rdata;
    logic                        w_rs_we;
    logic [mrm_pkg::RS_AW:0]     w_rs_waddr;
    logic [15:0]                 w_rs_wdata;
    logic                        w_rs_re;
    logic [mrm_pkg::RS_AW:0]     w_rs_raddr;
    logic [15:0]                 w_rs_rdata;

    // Transmit word store
    mrm_ram #(
        .DEPTH (mrm_pkg::TX_WORDS),
        .WIDTH (16)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (w_tx_we),
        .i_waddr (w_tx_waddr),
        .i_wdata (w_tx_wdata),
        .i_re    (w_tx_re),
        .i_raddr (w_tx_raddr),
        .o_rdata (w_tx_rdata)
    );

    // Response store, committed and staging banks
    mrm_ram #(
        .DEPTH (2 * mrm_pkg::RESP_WORDS),
        .WIDTH (16)
    ) u_rs_ram (
        .i_clk   (i_clk),
        .i_we    (w_rs_we),
        .i_waddr (w_rs_waddr),
        .i_wdata (w_rs_wdata),
        .i_re    (w_rs_re),
        .i_raddr (w_rs_raddr),
        .o_rdata (w_rs_rdata)
    );

    // Sequencer
    mrm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_tx_we    (w_tx_we),
        .o_tx_waddr (w_tx_waddr),
        .o_tx_wdata (w_tx_wdata),
        .o_tx_re    (w_tx_re),
        .o_tx_raddr (w_tx_raddr),
        .i_tx_rdata (w_tx_rdata),
        .o_rs_we    (w_rs_we),
        .o_rs_waddr (w_rs_waddr),
        .o_rs_wdata (w_rs_wdata),
        .o_rs_re    (w_rs_re),
        .o_rs_raddr (w_rs_raddr),
        .i_rs_rdata (w_rs_rdata)
    );

endmodule

`default_nettype wire
